// ===== rtl/core/wspr_pkg.sv =====
// shared constants, codes and controller/datapath types of the segment ranker
package wspr_pkg;

  // table size and field widths
  localparam int unsigned NUM_SEG = 16;
  localparam int unsigned SEG_W   = $clog2(NUM_SEG);
  localparam int unsigned CNT_W   = SEG_W + 1;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned COV_W   = 16;
  localparam int unsigned PRI_W   = 17;
  localparam int unsigned RANK_W  = 5;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned NSEG_W  = 5;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned CFGI_W  = 2;

  // sum of all scores and the divider operands
  localparam int unsigned SUM_W   = PRI_W + SEG_W;
  localparam int unsigned DVD_W   = 2 * PRI_W - 1;

  // fixed point constants
  localparam logic [PRI_W-1:0] ONE_Q16  = PRI_W'(65536);
  localparam logic [PRI_W-1:0] HALF_Q16 = PRI_W'(32768);
  localparam int unsigned      FULL_COV = 10000;
  localparam int unsigned      HALF_COV = 5000;
  localparam int unsigned      SAT_T    = 655370000;

  // divide by full coverage: drop 4 bits, then multiply by 2^35/625 rounded up
  localparam int unsigned      SC_RCP_W = 26;
  localparam logic [SC_RCP_W-1:0] SC_RCP = 26'd54975582;
  localparam int unsigned      SC_SHIFT = 35;

  // reset values of the registers
  localparam logic [NSEG_W-1:0] NSEG_RST = NSEG_W'(16);
  localparam logic [CFG_W-1:0]  CW_RST   = CFG_W'(45875);
  localparam logic [CFG_W-1:0]  SW_RST   = CFG_W'(19661);

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INIT      = 3'd0,
    REQ_UPDATE    = 3'd1,
    REQ_RECALC    = 3'd2,
    REQ_RECOMMEND = 3'd3,
    REQ_QUERY     = 3'd4
  } req_e;

  // register indexes
  typedef enum logic [CFGI_W-1:0] {
    CFG_NUM_SEGMENTS = 2'd0,
    CFG_COV_WEIGHT   = 2'd1,
    CFG_SUCC_WEIGHT  = 2'd2
  } cfg_e;

  // datapath operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_INIT,
    DP_UPD_WR,
    DP_SC_START,
    DP_PRI_WR,
    DP_PRI_WR_ACC,
    DP_NORM_START,
    DP_RANK_LD,
    DP_RANK_CMP,
    DP_RANK_WR,
    DP_REC_STEP,
    DP_OUT_SEG,
    DP_OUT_TOP,
    DP_OUT_REC,
    DP_OUT_INIT,
    DP_OUT_NONE
  } dp_op_e;

  // controller to datapath
  typedef struct packed {
    dp_op_e           op;
    logic [SEG_W-1:0] idx;
    logic [SEG_W-1:0] ri;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [SEG_W-1:0] seg;
    logic             seg_ok;
    logic [CNT_W-1:0] n;
    logic             sum_pos;
    logic             q_done;
    logic             out_free;
  } sts_t;

endpackage

// ===== rtl/core/wspr_if.sv =====
// request and result channel interfaces of the segment ranker
interface wspr_req_if;
  import wspr_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SEG_W-1:0]  segment;
  logic [COV_W-1:0]  coverage;
  logic [PRI_W-1:0]  success_rate;
  logic              success_given;
  logic [MASK_W-1:0] active_mask;

  modport source (output valid, req_type, segment, coverage, success_rate, success_given,
                  active_mask, input ready);
  modport sink (input valid, req_type, segment, coverage, success_rate, success_given,
                active_mask, output ready);
endinterface

interface wspr_rsp_if;
  import wspr_pkg::*;
  logic              valid;
  logic              ready;
  logic [SEG_W-1:0]  result_segment;
  logic [PRI_W-1:0]  result_priority;
  logic [RANK_W-1:0] result_rank;
  logic              found;

  modport source (output valid, result_segment, result_priority, result_rank, found,
                  input ready);
  modport sink (input valid, result_segment, result_priority, result_rank, found,
                output ready);
endinterface

// ===== rtl/core/wspr_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module wspr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wspr_pkg::DVD_W-1:0]    dividend_i,
  input  logic [wspr_pkg::SUM_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [wspr_pkg::PRI_W-1:0]    quot_o
);
  import wspr_pkg::*;

  localparam int unsigned DCNT_W = $clog2(PRI_W + 1);

  logic [SUM_W:0]      rem_q;
  logic [SUM_W-1:0]    div_q;
  logic [PRI_W-1:0]    dvd_q;
  logic [PRI_W-1:0]    quot_q;
  logic [DCNT_W-1:0]   cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [SUM_W:0]      trial;
  logic                qbit;
  logic [SUM_W:0]      rem_d;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_q[SUM_W-1:0], dvd_q[PRI_W-1]};
    qbit  = (trial >= {1'b0, div_q});
    rem_d = qbit ? (trial - {1'b0, div_q}) : trial;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(PRI_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and partial quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= (SUM_W + 1)'(dividend_i[DVD_W-1:PRI_W]);
      dvd_q  <= dividend_i[PRI_W-1:0];
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[PRI_W-2:0], 1'b0};
      quot_q <= {quot_q[PRI_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/wspr_dp.sv =====
// datapath: segment table, scoring pipeline, divider, ranking and result register
module wspr_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wspr_pkg::CFGI_W-1:0]  cfg_idx_i,
  input  logic [wspr_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [wspr_pkg::REQ_W-1:0]   req_type_i,
  input  logic [wspr_pkg::SEG_W-1:0]   segment_i,
  input  logic [wspr_pkg::COV_W-1:0]   coverage_i,
  input  logic [wspr_pkg::PRI_W-1:0]   success_rate_i,
  input  logic                         success_given_i,
  input  logic [wspr_pkg::MASK_W-1:0]  active_mask_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output logic [wspr_pkg::SEG_W-1:0]   result_segment_o,
  output logic [wspr_pkg::PRI_W-1:0]   result_priority_o,
  output logic [wspr_pkg::RANK_W-1:0]  result_rank_o,
  output logic                         found_o,
  input  wspr_pkg::cmd_t               cmd_i,
  output wspr_pkg::sts_t               sts_o
);
  import wspr_pkg::*;

  // configuration
  logic [NSEG_W-1:0] nseg_q;
  logic [CFG_W-1:0]  cw_q;
  logic [CFG_W-1:0]  sw_q;
  logic [CNT_W-1:0]  n;

  // captured item
  logic [REQ_W-1:0]  req_q;
  logic [SEG_W-1:0]  seg_q;
  logic [COV_W-1:0]  cov_q;
  logic [PRI_W-1:0]  succ_q;
  logic              given_q;
  logic [MASK_W-1:0] mask_q;

  // segment table
  logic [COV_W-1:0]  cov_st  [NUM_SEG];
  logic [PRI_W-1:0]  succ_st [NUM_SEG];
  logic [PRI_W-1:0]  pri_st  [NUM_SEG];
  logic [RANK_W-1:0] rank_st [NUM_SEG];
  logic [COV_W-1:0]  cov_rd;
  logic [PRI_W-1:0]  succ_rd;
  logic [PRI_W-1:0]  pri_rd;
  logic [RANK_W-1:0] rank_rd;

  // scoring pipeline
  logic [COV_W-1:0]   sc_cov_q;
  logic [PRI_W-1:0]   sc_succ_q;
  logic               sc_go_q;
  logic               s1_q;
  logic               s2_q;
  logic               s3_q;
  logic signed [17:0] diff;
  logic signed [35:0] a_q;
  logic signed [35:0] a2_q;
  logic [30:0]        b_q;
  logic [47:0]        c_q;
  logic signed [52:0] num;
  logic               pos_q;
  logic [DVD_W-1:0]   t_q;
  logic [2*SC_RCP_W-1:0] sc_prod;

  // quotient handling
  logic               qd_q;
  logic [PRI_W-1:0]   qdir_q;
  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [SUM_W-1:0]   div_dsr;
  logic               div_done;
  logic [PRI_W-1:0]   div_quot;
  logic [PRI_W-1:0]   q_val;
  logic [SUM_W-1:0]   sum_q;

  // ranking and recommend
  logic [PRI_W-1:0]  pi_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SEG_W-1:0]  top_q;
  logic [PRI_W-1:0]  top_p_q;
  logic [RANK_W-1:0] top_r_q;
  logic              any_q;
  logic [SEG_W-1:0]  best_q;
  logic [PRI_W-1:0]  best_p_q;
  logic [RANK_W-1:0] best_r_q;

  // result register
  logic              rsp_valid_q;
  logic [SEG_W-1:0]  res_seg_q;
  logic [PRI_W-1:0]  res_pri_q;
  logic [RANK_W-1:0] res_rank_q;
  logic              res_found_q;
  logic              out_op;

  // effective segment count
  always_comb begin
    if (int'(nseg_q) > int'(NUM_SEG)) n = CNT_W'(NUM_SEG);
    else n = CNT_W'(nseg_q);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nseg_q <= NSEG_RST;
      cw_q   <= CW_RST;
      sw_q   <= SW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_SEGMENTS: nseg_q <= cfg_wdata_i[NSEG_W-1:0];
        CFG_COV_WEIGHT:   cw_q   <= cfg_wdata_i;
        CFG_SUCC_WEIGHT:  sw_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      req_q   <= req_type_i;
      seg_q   <= segment_i;
      cov_q   <= coverage_i;
      succ_q  <= success_rate_i;
      given_q <= success_given_i;
      mask_q  <= active_mask_i;
    end
  end

  // table read port
  always_comb begin
    cov_rd  = cov_st[cmd_i.idx];
    succ_rd = succ_st[cmd_i.idx];
    pri_rd  = pri_st[cmd_i.idx];
    rank_rd = rank_st[cmd_i.idx];
  end

  // table writes, reset and init restore the defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SEG; k++) begin
        cov_st[k]  <= '0;
        succ_st[k] <= HALF_Q16;
        pri_st[k]  <= ONE_Q16;
        rank_st[k] <= RANK_W'(k + 1);
      end
    end else begin
      case (cmd_i.op)
        DP_INIT: begin
          for (int k = 0; k < NUM_SEG; k++) begin
            cov_st[k]  <= '0;
            succ_st[k] <= HALF_Q16;
            pri_st[k]  <= ONE_Q16;
            rank_st[k] <= RANK_W'(k + 1);
          end
        end
        DP_UPD_WR: begin
          cov_st[cmd_i.idx] <= cov_q;
          if (given_q) succ_st[cmd_i.idx] <= succ_q;
        end
        DP_PRI_WR, DP_PRI_WR_ACC: pri_st[cmd_i.idx] <= q_val;
        DP_RANK_WR: rank_st[cmd_i.ri] <= RANK_W'(cnt_q);
        default: ;
      endcase
    end
  end

  // pipeline control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_go_q <= 1'b0;
      s1_q    <= 1'b0;
      s2_q    <= 1'b0;
      s3_q    <= 1'b0;
      qd_q    <= 1'b0;
    end else begin
      sc_go_q <= (cmd_i.op == DP_UPD_WR) || (cmd_i.op == DP_SC_START);
      s1_q    <= sc_go_q;
      s2_q    <= s1_q;
      s3_q    <= s2_q;
      qd_q    <= s3_q;
    end
  end

  // score operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_UPD_WR) begin
      sc_cov_q  <= cov_q;
      sc_succ_q <= given_q ? succ_q : succ_rd;
    end else if (cmd_i.op == DP_SC_START) begin
      sc_cov_q  <= cov_rd;
      sc_succ_q <= succ_rd;
    end
  end

  // score stages: weighted shortfall, success product, its weight, sum, then the divide
  assign diff = 18'(FULL_COV) - $signed({2'b00, sc_cov_q});
  assign num  = (53'(a2_q) <<< 16) + $signed({5'b00000, c_q});
  assign sc_prod = (2*SC_RCP_W)'(t_q[29:4]) * (2*SC_RCP_W)'(SC_RCP);

  always_ff @(posedge clk_i) begin
    if (sc_go_q) begin
      a_q <= $signed({1'b0, cw_q}) * diff;
      b_q <= 31'(sc_succ_q) * 31'(FULL_COV);
    end
    if (s1_q) begin
      a2_q <= a_q;
      c_q  <= 48'(sw_q) * 48'(b_q);
    end
    if (s2_q) begin
      pos_q <= (num > 53'sd0);
      t_q   <= DVD_W'(num[47:16]) + DVD_W'(HALF_COV);
    end
    if (s3_q) begin
      if (!pos_q) qdir_q <= '0;
      else if (t_q >= DVD_W'(SAT_T)) qdir_q <= ONE_Q16;
      else qdir_q <= sc_prod[SC_SHIFT +: PRI_W];
    end
  end

  // divider: priority over the sum
  assign div_start = (cmd_i.op == DP_NORM_START);
  assign div_dvd   = {pri_rd, 16'h0000} + DVD_W'(sum_q >> 1);
  assign div_dsr   = sum_q;

  wspr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign q_val = div_done ? div_quot : qdir_q;

  // score sum, ranking and recommend state
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        sum_q <= '0;
        any_q <= 1'b0;
      end
      DP_PRI_WR_ACC: sum_q <= sum_q + SUM_W'(q_val);
      DP_RANK_LD: begin
        pi_q  <= pri_rd;
        cnt_q <= CNT_W'(1);
      end
      DP_RANK_CMP: begin
        if ((pri_rd > pi_q) || ((pri_rd == pi_q) && (cmd_i.idx < cmd_i.ri)))
          cnt_q <= cnt_q + 1'b1;
      end
      DP_RANK_WR: begin
        if (cnt_q == CNT_W'(1)) begin
          top_q   <= cmd_i.ri;
          top_p_q <= pi_q;
          top_r_q <= RANK_W'(cnt_q);
        end
      end
      DP_REC_STEP: begin
        if (mask_q[cmd_i.idx] && (!any_q || (pri_rd > best_p_q))) begin
          any_q    <= 1'b1;
          best_q   <= cmd_i.idx;
          best_p_q <= pri_rd;
          best_r_q <= rank_rd;
        end
      end
      default: ;
    endcase
  end

  // result register
  assign out_op = (cmd_i.op == DP_OUT_SEG) || (cmd_i.op == DP_OUT_TOP) ||
                  (cmd_i.op == DP_OUT_REC) || (cmd_i.op == DP_OUT_INIT) ||
                  (cmd_i.op == DP_OUT_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (out_op) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_OUT_SEG: begin
        res_seg_q   <= seg_q;
        res_pri_q   <= sts_o.seg_ok ? pri_rd : '0;
        res_rank_q  <= sts_o.seg_ok ? rank_rd : '0;
        res_found_q <= sts_o.seg_ok;
      end
      DP_OUT_TOP: begin
        res_seg_q   <= top_q;
        res_pri_q   <= top_p_q;
        res_rank_q  <= top_r_q;
        res_found_q <= 1'b1;
      end
      DP_OUT_REC: begin
        res_seg_q   <= any_q ? best_q : '0;
        res_pri_q   <= any_q ? best_p_q : '0;
        res_rank_q  <= any_q ? best_r_q : '0;
        res_found_q <= any_q;
      end
      DP_OUT_INIT: begin
        res_seg_q   <= '0;
        res_pri_q   <= '0;
        res_rank_q  <= '0;
        res_found_q <= 1'b1;
      end
      DP_OUT_NONE: begin
        res_seg_q   <= '0;
        res_pri_q   <= '0;
        res_rank_q  <= '0;
        res_found_q <= 1'b0;
      end
      default: ;
    endcase
  end

  assign rsp_valid_o       = rsp_valid_q;
  assign result_segment_o  = res_seg_q;
  assign result_priority_o = res_pri_q;
  assign result_rank_o     = res_rank_q;
  assign found_o           = res_found_q;

  // status
  always_comb begin
    sts_o.req_type = req_q;
    sts_o.seg      = seg_q;
    sts_o.seg_ok   = ({1'b0, seg_q} < n);
    sts_o.n        = n;
    sts_o.sum_pos  = (sum_q != '0);
    sts_o.q_done   = div_done || qd_q;
    sts_o.out_free = !rsp_valid_q || rsp_ready_i;
  end

endmodule

// ===== rtl/core/wspr_ctrl.sv =====
// controller: sequences each request over the datapath
module wspr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  wspr_pkg::sts_t sts_i,
  output wspr_pkg::cmd_t cmd_o
);
  import wspr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UPD,
    S_UPD_WAIT,
    S_SC,
    S_SC_WAIT,
    S_NORM_CHK,
    S_NORM,
    S_NORM_WAIT,
    S_RK_LD,
    S_RK_CMP,
    S_RK_WR,
    S_REC,
    S_OUT
  } state_e;

  state_e           state_q;
  dp_op_e           out_op_q;
  logic [SEG_W-1:0] i_q;
  logic [SEG_W-1:0] j_q;
  logic             last_i;
  logic             last_j;

  assign last_i = (CNT_W'(i_q) + 1'b1) == sts_i.n;
  assign last_j = (CNT_W'(j_q) + 1'b1) == sts_i.n;
  assign req_ready_o = (state_q == S_IDLE);

  // operation of each state
  always_comb begin
    cmd_o.op  = DP_NOP;
    cmd_o.idx = i_q;
    cmd_o.ri  = i_q;
    case (state_q)
      S_IDLE:      if (req_valid_i) cmd_o.op = DP_LOAD;
      S_DISPATCH:  if (sts_i.req_type == REQ_INIT) cmd_o.op = DP_INIT;
      S_UPD: begin
        cmd_o.op  = DP_UPD_WR;
        cmd_o.idx = sts_i.seg;
      end
      S_UPD_WAIT: begin
        cmd_o.idx = sts_i.seg;
        if (sts_i.q_done) cmd_o.op = DP_PRI_WR;
      end
      S_SC:        cmd_o.op = DP_SC_START;
      S_SC_WAIT:   if (sts_i.q_done) cmd_o.op = DP_PRI_WR_ACC;
      S_NORM:      cmd_o.op = DP_NORM_START;
      S_NORM_WAIT: if (sts_i.q_done) cmd_o.op = DP_PRI_WR;
      S_RK_LD:     cmd_o.op = DP_RANK_LD;
      S_RK_CMP: begin
        cmd_o.op  = DP_RANK_CMP;
        cmd_o.idx = j_q;
      end
      S_RK_WR:     cmd_o.op = DP_RANK_WR;
      S_REC:       cmd_o.op = DP_REC_STEP;
      S_OUT: begin
        cmd_o.idx = sts_i.seg;
        if (sts_i.out_free) cmd_o.op = out_op_q;
      end
      default: ;
    endcase
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      out_op_q <= DP_OUT_NONE;
      i_q      <= '0;
      j_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          i_q     <= '0;
          state_q <= S_OUT;
          case (sts_i.req_type)
            REQ_INIT: out_op_q <= DP_OUT_INIT;
            REQ_UPDATE: begin
              out_op_q <= DP_OUT_SEG;
              if (sts_i.seg_ok) state_q <= S_UPD;
            end
            REQ_QUERY: out_op_q <= DP_OUT_SEG;
            REQ_RECALC: begin
              out_op_q <= DP_OUT_TOP;
              if (sts_i.n == '0) out_op_q <= DP_OUT_NONE;
              else state_q <= S_SC;
            end
            REQ_RECOMMEND: begin
              out_op_q <= DP_OUT_REC;
              if (sts_i.n != '0) state_q <= S_REC;
            end
            default: out_op_q <= DP_OUT_NONE;
          endcase
        end
        S_UPD:      state_q <= S_UPD_WAIT;
        S_UPD_WAIT: if (sts_i.q_done) state_q <= S_OUT;
        S_SC:       state_q <= S_SC_WAIT;
        S_SC_WAIT: begin
          if (sts_i.q_done) begin
            if (last_i) begin
              i_q     <= '0;
              state_q <= S_NORM_CHK;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_SC;
            end
          end
        end
        S_NORM_CHK: state_q <= sts_i.sum_pos ? S_NORM : S_RK_LD;
        S_NORM:     state_q <= S_NORM_WAIT;
        S_NORM_WAIT: begin
          if (sts_i.q_done) begin
            if (last_i) begin
              i_q     <= '0;
              state_q <= S_RK_LD;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_NORM;
            end
          end
        end
        S_RK_LD: begin
          j_q     <= '0;
          state_q <= S_RK_CMP;
        end
        S_RK_CMP: begin
          if (last_j) state_q <= S_RK_WR;
          else j_q <= j_q + 1'b1;
        end
        S_RK_WR: begin
          if (last_i) begin
            state_q <= S_OUT;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_RK_LD;
          end
        end
        S_REC: begin
          if (last_i) state_q <= S_OUT;
          else i_q <= i_q + 1'b1;
        end
        S_OUT: if (sts_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/weighted_segment_priority_ranker.sv =====
// top level of the weighted segment priority ranker
//
//   channel   dir  handshake     payload
//   req_i     in   valid/ready   req_type, segment, coverage, success_rate,
//                                success_given, active_mask
//   rsp_o     out  valid/ready   result_segment, result_priority, result_rank, found
//   cfg       in   cfg_we_i      cfg_idx_i, cfg_wdata_i
//
// one item at a time; init, query, undefined and invalid requests go straight to the
// result, update adds the multiply stages and a reciprocal multiply for the coverage
// divide, recommend steps over the segments, recalc scores each segment, runs the
// 17-step normalize divide per segment if the sum is nonzero, then the pairwise rank
// compare over one table read port. a finished result waits in the output register
// while the next item is taken; a second result stalls until the first is taken.
// reset restores the table defaults and the register reset values.
module weighted_segment_priority_ranker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  wspr_req_if.sink                    req_i,
  wspr_rsp_if.source                  rsp_o,
  input  logic                        cfg_we_i,
  input  logic [wspr_pkg::CFGI_W-1:0] cfg_idx_i,
  input  logic [wspr_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import wspr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // request sequencer
  wspr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // table and arithmetic
  wspr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_type_i        (req_i.req_type),
    .segment_i         (req_i.segment),
    .coverage_i        (req_i.coverage),
    .success_rate_i    (req_i.success_rate),
    .success_given_i   (req_i.success_given),
    .active_mask_i     (req_i.active_mask),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .result_segment_o  (rsp_o.result_segment),
    .result_priority_o (rsp_o.result_priority),
    .result_rank_o     (rsp_o.result_rank),
    .found_o           (rsp_o.found),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench of the weighted segment priority ranker
`timescale 1ns / 100ps

module tb_top;
  import wspr_pkg::*;

  // request codes outside the defined set
  localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 3'd7;
  localparam int unsigned      ITEMS_PER_PHASE = 100;
  localparam int unsigned      NUM_PHASES      = 8;
  localparam int unsigned      SETTLE_CYCLES   = 40;
  localparam int unsigned      HOLD_CYCLES     = 400;

  typedef struct {
    logic [REQ_W-1:0]  req_type;
    logic [SEG_W-1:0]  segment;
    logic [COV_W-1:0]  coverage;
    logic [PRI_W-1:0]  success_rate;
    logic              success_given;
    logic [MASK_W-1:0] active_mask;
  } request_t;

  typedef struct {
    logic [SEG_W-1:0]  seg;
    logic [PRI_W-1:0]  pri;
    logic [RANK_W-1:0] rank;
    logic              found;
  } ranking_t;

  // scoreboard: keeps its own segment table and predicts each result
  class segment_table_scoreboard;
    logic [COV_W-1:0]  cov_tab[NUM_SEG];
    logic [PRI_W-1:0]  succ_tab[NUM_SEG];
    logic [PRI_W-1:0]  pri_tab[NUM_SEG];
    logic [RANK_W-1:0] rank_tab[NUM_SEG];
    logic [NSEG_W-1:0] num_seg;
    logic [CFG_W-1:0]  cov_wt;
    logic [CFG_W-1:0]  succ_wt;
    ranking_t          expected_rankings[$];
    int unsigned       mismatches;

    function new();
      num_seg    = NSEG_RST;
      cov_wt     = CW_RST;
      succ_wt    = SW_RST;
      mismatches = 0;
      restore_table();
    endfunction

    function void restore_table();
      for (int i = 0; i < NUM_SEG; i++) begin
        cov_tab[i]  = '0;
        succ_tab[i] = HALF_Q16;
        pri_tab[i]  = ONE_Q16;
        rank_tab[i] = RANK_W'(i + 1);
      end
    endfunction

    function void write_reg(cfg_e idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_NUM_SEGMENTS: num_seg = value[NSEG_W-1:0];
        CFG_COV_WEIGHT:   cov_wt  = value;
        CFG_SUCC_WEIGHT:  succ_wt = value;
        default: ;
      endcase
    endfunction

    // weighted score, rounded half up and clamped to 1.0
    function logic [PRI_W-1:0] weighted_score(logic [COV_W-1:0] cov, logic [PRI_W-1:0] succ);
      longint num, den, q;
      den = longint'(FULL_COV) * 65536;
      num = longint'(cov_wt) * (longint'(FULL_COV) - longint'(cov)) * 65536
          + longint'(succ_wt) * longint'(succ) * longint'(FULL_COV);
      if (num <= 0) return '0;
      q = (num + den / 2) / den;
      if (q > 65536) q = 65536;
      return PRI_W'(q);
    endfunction

    function void note_request(request_t r);
      ranking_t    res;
      int unsigned n, top, cnt;
      longint      sum;
      bit          any;
      n   = (num_seg < NUM_SEG) ? num_seg : NUM_SEG;
      res = '{seg: '0, pri: '0, rank: '0, found: 1'b0};
      case (r.req_type)
        REQ_INIT: begin
          restore_table();
          res.found = 1'b1;
        end
        REQ_UPDATE, REQ_QUERY: begin
          res.seg = r.segment;
          if (r.segment < n) begin
            if (r.req_type == REQ_UPDATE) begin
              cov_tab[r.segment] = r.coverage;
              if (r.success_given) succ_tab[r.segment] = r.success_rate;
              pri_tab[r.segment] = weighted_score(r.coverage, succ_tab[r.segment]);
            end
            res.pri   = pri_tab[r.segment];
            res.rank  = rank_tab[r.segment];
            res.found = 1'b1;
          end
        end
        REQ_RECALC: begin
          if (n != 0) begin
            sum = 0;
            top = 0;
            for (int i = 0; i < n; i++) begin
              pri_tab[i] = weighted_score(cov_tab[i], succ_tab[i]);
              sum += pri_tab[i];
            end
            // normalize to a unit sum
            if (sum > 0)
              for (int i = 0; i < n; i++)
                pri_tab[i] = PRI_W'((longint'(pri_tab[i]) * 65536 + sum / 2) / sum);
            // descending priority, ties to the lower index
            for (int i = 0; i < n; i++) begin
              cnt = 1;
              for (int j = 0; j < n; j++)
                if (pri_tab[j] > pri_tab[i] || (pri_tab[j] == pri_tab[i] && j < i)) cnt++;
              rank_tab[i] = RANK_W'(cnt);
              if (cnt == 1) top = i;
            end
            res = '{seg: SEG_W'(top), pri: pri_tab[top], rank: rank_tab[top], found: 1'b1};
          end
        end
        REQ_RECOMMEND: begin
          any = 1'b0;
          top = 0;
          for (int i = 0; i < n; i++)
            if (r.active_mask[i] && (!any || pri_tab[i] > pri_tab[top])) begin
              top = i;
              any = 1'b1;
            end
          if (any) res = '{seg: SEG_W'(top), pri: pri_tab[top], rank: rank_tab[top], found: 1'b1};
        end
        default: ;
      endcase
      expected_rankings = {expected_rankings, res};
    endfunction

    function void check_result(ranking_t act);
      ranking_t exp_r;
      if (expected_rankings.size() == 0) begin
        $error("result with no request pending: seg %0d pri %0d", act.seg, act.pri);
        mismatches++;
        return;
      end
      exp_r = expected_rankings.pop_front();
      if (act.seg !== exp_r.seg) begin
        $error("result_segment: expected %0d actual %0d", exp_r.seg, act.seg);
        mismatches++;
      end
      if (act.pri !== exp_r.pri) begin
        $error("result_priority: expected %0d actual %0d", exp_r.pri, act.pri);
        mismatches++;
      end
      if (act.rank !== exp_r.rank) begin
        $error("result_rank: expected %0d actual %0d", exp_r.rank, act.rank);
        mismatches++;
      end
      if (act.found !== exp_r.found) begin
        $error("found: expected %0d actual %0d", exp_r.found, act.found);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFGI_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  bit                  hold_request;
  int unsigned         hold_left;
  segment_table_scoreboard sb;

  wspr_req_if req_ch ();
  wspr_rsp_if rsp_ch ();

  weighted_segment_priority_ranker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // overall time limit
  initial begin
    #(64'd100000000);
    $display("tb: failure");
    $finish;
  end

  // result side: check accepted items, random stalls and one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready)
      sb.check_result('{seg: rsp_ch.result_segment, pri: rsp_ch.result_priority,
                        rank: rsp_ch.result_rank, found: rsp_ch.found});
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one item and wait for it to be taken
  task automatic send_request(request_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= r.req_type;
    req_ch.segment       <= r.segment;
    req_ch.coverage      <= r.coverage;
    req_ch.success_rate  <= r.success_rate;
    req_ch.success_given <= r.success_given;
    req_ch.active_mask   <= r.active_mask;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sb.note_request(r);
  endtask

  function automatic request_t make_request(logic [REQ_W-1:0] t, int unsigned seg,
                                            int unsigned cov, int unsigned succ,
                                            bit given, int unsigned mask);
    request_t r;
    r.req_type      = t;
    r.segment       = SEG_W'(seg);
    r.coverage      = COV_W'(cov);
    r.success_rate  = PRI_W'(succ);
    r.success_given = given;
    r.active_mask   = MASK_W'(mask);
    return r;
  endfunction

  // mostly updates and reads with a few full rescores
  function automatic request_t random_request();
    int unsigned pick, cov, succ;
    logic [REQ_W-1:0] t;
    pick = $urandom_range(99);
    if (pick < 2)       t = REQ_INIT;
    else if (pick < 48) t = REQ_UPDATE;
    else if (pick < 56) t = REQ_RECALC;
    else if (pick < 74) t = REQ_RECOMMEND;
    else if (pick < 96) t = REQ_QUERY;
    else                t = REQ_UNDEF_LO + REQ_W'($urandom_range(2));
    cov  = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(FULL_COV);
    succ = ($urandom_range(7) == 0) ? ONE_Q16 : $urandom_range(65535);
    return make_request(t, $urandom_range(NUM_SEG - 1), cov, succ, 1'($urandom_range(1)),
                        $urandom_range(65535));
  endfunction

  task automatic write_reg(cfg_e idx, int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(idx, CFG_W'(value));
  endtask

  task automatic wait_drained();
    while (sb.expected_rankings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic directed_requests();
    send_request(make_request(REQ_INIT, 0, 0, 0, 0, 0));
    send_request(make_request(REQ_QUERY, 3, 0, 0, 0, 0));
    send_request(make_request(REQ_RECOMMEND, 0, 0, 0, 0, 16'hffff));
    send_request(make_request(REQ_UPDATE, 0, 0, ONE_Q16, 1, 0));
    send_request(make_request(REQ_UPDATE, 1, 65535, 0, 1, 0));
    send_request(make_request(REQ_UPDATE, 2, FULL_COV, 0, 0, 0));
    send_request(make_request(REQ_UPDATE, 15, 2500, 131071, 1, 0));
    send_request(make_request(REQ_UPDATE, 7, 0, 0, 1, 0));
    send_request(make_request(REQ_QUERY, 15, 0, 0, 0, 0));
    send_request(make_request(REQ_RECALC, 0, 0, 0, 0, 0));
    send_request(make_request(REQ_QUERY, 0, 0, 0, 0, 0));
    send_request(make_request(REQ_RECOMMEND, 0, 0, 0, 0, 0));
    send_request(make_request(REQ_RECOMMEND, 0, 0, 0, 0, 16'h8002));
    send_request(make_request(REQ_RECOMMEND, 0, 0, 0, 0, 16'hffff));
    send_request(make_request(REQ_UNDEF_LO, 4, 100, 100, 1, 16'hffff));
    send_request(make_request(REQ_UNDEF_HI, 4, 100, 100, 1, 16'hffff));
    send_request(make_request(REQ_UNDEF_LO + 3'd1, 4, 100, 100, 1, 16'hffff));
    send_request(make_request(REQ_INIT, 9, 9, 9, 1, 9));
    send_request(make_request(REQ_RECALC, 0, 0, 0, 0, 0));
  endtask

  // main sequence: reset, then phases of settings and items
  initial begin
    int unsigned w;
    sb                   = new();
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_NUM_SEGMENTS;
    cfg_wdata_i          = '0;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_INIT;
    req_ch.segment       = '0;
    req_ch.coverage      = '0;
    req_ch.success_rate  = '0;
    req_ch.success_given = 1'b0;
    req_ch.active_mask   = '0;
    rsp_ch.ready         = 1'b0;
    send_idle_pct        = 14;
    recv_idle_pct        = 82;
    hold_request         = 1'b0;
    hold_left            = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // idle pattern per phase
      if (p < 3) begin
        send_idle_pct = 14;
        recv_idle_pct = 82;
      end else if (p < 6) begin
        send_idle_pct = 82;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // settings per phase, extremes included
      case (p)
        1: begin
          write_reg(CFG_NUM_SEGMENTS, 16);
          write_reg(CFG_COV_WEIGHT, 65536);
          write_reg(CFG_SUCC_WEIGHT, 0);
        end
        2: begin
          write_reg(CFG_NUM_SEGMENTS, 1);
          write_reg(CFG_COV_WEIGHT, 0);
          write_reg(CFG_SUCC_WEIGHT, 65536);
        end
        3: write_reg(CFG_NUM_SEGMENTS, 0);
        4: begin
          write_reg(CFG_NUM_SEGMENTS, 5);
          write_reg(CFG_COV_WEIGHT, 0);
          write_reg(CFG_SUCC_WEIGHT, 0);
        end
        5: begin
          write_reg(CFG_NUM_SEGMENTS, 31);
          write_reg(CFG_COV_WEIGHT, $urandom_range(65536));
          write_reg(CFG_SUCC_WEIGHT, $urandom_range(65536));
        end
        6: begin
          w = $urandom_range(65536);
          write_reg(CFG_NUM_SEGMENTS, $urandom_range(2, 16));
          write_reg(CFG_COV_WEIGHT, w);
          write_reg(CFG_SUCC_WEIGHT, 65536 - w);
        end
        7: begin
          write_reg(CFG_NUM_SEGMENTS, 16);
          write_reg(CFG_COV_WEIGHT, CW_RST);
          write_reg(CFG_SUCC_WEIGHT, SW_RST);
        end
        default: ;
      endcase
      if (p == 0) directed_requests();
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // long result hold-off while items keep coming
        if (p == 1 && k == 10) hold_request = 1'b1;
        // sender pauses until all results are back
        if (p == 4 && k == 50) begin
          req_ch.valid <= 1'b0;
          while (sb.expected_rankings.size() != 0) @(posedge clk_i);
        end
        send_request(random_request());
      end
      req_ch.valid <= 1'b0;
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.expected_rankings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/wspr_pkg.sv
rtl/core/wspr_if.sv
rtl/core/wspr_div.sv
rtl/core/wspr_dp.sv
rtl/core/wspr_ctrl.sv
rtl/core/weighted_segment_priority_ranker.sv
dv/tb_top.sv
